// ===== design/sgdr_pkg.sv =====
// Shared types, codes and sizes for the audio DMA descriptor ring block.
// Used by the controller, the datapath, the top level and the port checker.
package sgdr_pkg;

    // Default parameter values for the top level
    localparam int SGDR_RING_DEPTH = 64;
    localparam int SGDR_PAGE_BYTES = 4096;

    // Hard limit on the ring size in use per channel
    localparam int RES_CAP = 64;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 32;
    localparam int CNT_W   = 19;
    localparam int TAG_W   = 16;
    localparam int SEQ_W   = 6;
    localparam int CFG_W   = 7;
    localparam int KIND_W  = 3;
    localparam int IDX_W   = 6;
    localparam int CLEN_W  = 13;

    // Packed stream widths, padded to whole bytes
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 72;

    localparam logic [CFG_W-1:0] RING_ENTRIES_RST = 7'd64;

    // Commands
    localparam logic [CMD_W-1:0] CMD_SUBMIT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COMPLETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_HALT     = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DESC    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DONE    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ABORT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOSPACE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic load;         // capture the accepted request
        logic push_reject;  // emit a no-space or empty-request result
        logic push_chunk;   // write one descriptor
        logic rd_req;       // read the tag of the oldest active entry
        logic retire;       // retire the oldest active entry
        logic flush;        // release the held result as the final one
    } sgdr_ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             zero_count;
        logic             no_space;
        logic             chunk_more;
        logic             ring_empty;
        logic             ret_stop;
        logic             tag_nz;
        logic             can_push;
    } sgdr_stat_t;

endpackage

// ===== design/sgdr_ctrl.sv =====
// Sequencing state machine of the descriptor ring block.
// Depends on sgdr_pkg for the command and status structs and the command codes.
module sgdr_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  sgdr_pkg::sgdr_stat_t   stat,
    output sgdr_pkg::sgdr_ctl_t    ctl
);
    import sgdr_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_CHECK    = 3'd2;
    localparam logic [2:0] ST_CHUNK    = 3'd3;
    localparam logic [2:0] ST_READ     = 3'd4;
    localparam logic [2:0] ST_RETIRE   = 3'd5;
    localparam logic [2:0] ST_FLUSH    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctl.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (stat.cmd)
                    CMD_SUBMIT:   state_next = ST_CHECK;
                    CMD_COMPLETE: state_next = ST_READ;
                    CMD_HALT:     state_next = ST_READ;
                    default:      state_next = ST_IDLE;
                endcase
            end
            ST_CHECK: begin
                if (stat.zero_count || stat.no_space) begin
                    if (stat.can_push) begin
                        ctl.push_reject = 1'b1;
                        state_next      = ST_FLUSH;
                    end
                end else begin
                    state_next = ST_CHUNK;
                end
            end
            ST_CHUNK: begin
                if (stat.can_push) begin
                    ctl.push_chunk = 1'b1;
                    state_next     = stat.chunk_more ? ST_CHUNK : ST_FLUSH;
                end
            end
            ST_READ: begin
                if (stat.ring_empty) begin
                    state_next = ST_FLUSH;
                end else begin
                    ctl.rd_req = 1'b1;
                    state_next = ST_RETIRE;
                end
            end
            ST_RETIRE: begin
                if (!stat.tag_nz || stat.can_push) begin
                    ctl.retire = 1'b1;
                    state_next = stat.ret_stop ? ST_FLUSH : ST_READ;
                end
            end
            ST_FLUSH: begin
                if (stat.can_push) begin
                    ctl.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/sgdr_datapath.sv =====
// Ring indices, tag store, chunk splitter and result staging of the ring block.
// Depends on sgdr_pkg for widths, codes and the command and status structs.
module sgdr_datapath #(
    parameter int RING_DEPTH = sgdr_pkg::SGDR_RING_DEPTH,
    parameter int PAGE_BYTES = sgdr_pkg::SGDR_PAGE_BYTES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [sgdr_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [sgdr_pkg::CMD_W-1:0]      s_tuser,
    input  logic                            cfg_valid,
    input  logic [sgdr_pkg::CFG_W-1:0]      cfg_data,
    input  sgdr_pkg::sgdr_ctl_t             ctl,
    output sgdr_pkg::sgdr_stat_t            stat,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sgdr_pkg::M_DATA_W-1:0]   m_tdata,
    output logic [sgdr_pkg::KIND_W-1:0]     m_tuser,
    output logic                            m_tlast
);
    import sgdr_pkg::*;

    // PAGE_BYTES is a power of two
    localparam int IW      = $clog2(RING_DEPTH);
    localparam int PG_W    = $clog2(PAGE_BYTES);
    localparam int LEN_W   = PG_W + 1;
    localparam int EFF_MAX = (RING_DEPTH < RES_CAP) ? RING_DEPTH : RES_CAP;
    localparam int CW      = (IW + 1 > CFG_W) ? IW + 1 : CFG_W;
    localparam int NEED_W  = CNT_W - PG_W + 2;
    localparam int NC_W    = (NEED_W > CFG_W) ? NEED_W : CFG_W;
    localparam int MEM_D   = 2 ** (IW + 1);

    localparam logic [CFG_W-1:0] SIZE_MAX = CFG_W'(EFF_MAX);
    localparam logic [IW-1:0]    LAST_RST = IW'(EFF_MAX - 1);
    localparam logic [LEN_W-1:0] PAGE_LEN = LEN_W'(PAGE_BYTES);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              dir;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] addr;
        logic [CLEN_W-1:0] len;
        logic [TAG_W-1:0]  tag;
        logic              irq;
    } res_t;

    logic [CFG_W-1:0]  ring_entries_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic              dir_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [SEQ_W-1:0]  seq_reg;

    logic [IW-1:0]     last_index_reg   [2];
    logic [IW-1:0]     expect_index_reg [2];
    logic [CFG_W-1:0]  active_count_reg [2];

    logic [TAG_W-1:0]  tag_mem [MEM_D];
    logic [TAG_W-1:0]  rd_data_reg;

    res_t              pend_reg;
    logic              pend_valid_reg;
    logic              pend_valid_next;
    res_t              out_reg;
    logic              out_last_reg;
    logic              m_tvalid_reg;
    logic              m_tvalid_next;

    logic [CFG_W-1:0]  size_c;
    logic [IW-1:0]     cur_last;
    logic [IW-1:0]     cur_exp;
    logic [CFG_W-1:0]  cur_act;
    logic [LEN_W-1:0]  room;
    logic [LEN_W-1:0]  resid;
    logic [NEED_W-1:0] need;
    logic              chunk_last;
    logic [LEN_W-1:0]  len_c;
    logic [TAG_W-1:0]  ctag;
    logic [CW-1:0]     idx_inc;
    logic [IW-1:0]     chunk_idx;
    logic [CW-1:0]     exp_inc;
    logic [IW-1:0]     exp_wrap;
    logic [CFG_W-1:0]  act_inc;
    logic              push_en;
    logic              out_free;
    res_t              new_res;
    logic              mem_we;
    logic [IW:0]       mem_wa;
    logic [TAG_W-1:0]  mem_wd;

    // Clamp the ring size to 1..EFF_MAX
    always_comb begin
        if (ring_entries_reg == '0) begin
            size_c = CFG_W'(1);
        end else if (ring_entries_reg > SIZE_MAX) begin
            size_c = SIZE_MAX;
        end else begin
            size_c = ring_entries_reg;
        end
    end

    assign cur_last = last_index_reg[dir_reg];
    assign cur_exp  = expect_index_reg[dir_reg];
    assign cur_act  = active_count_reg[dir_reg];

    // Page split: room up to the next boundary, a whole page when aligned
    assign room  = PAGE_LEN - {1'b0, addr_reg[PG_W-1:0]};
    assign resid = (addr_reg[PG_W-1:0] == '0) ? '0 : room;
    assign need  = NEED_W'(count_reg >> PG_W)
                 + NEED_W'(resid != '0)
                 + NEED_W'((resid != '0) && (CNT_W'(resid) < count_reg));

    assign chunk_last = (count_reg <= CNT_W'(room));
    assign len_c      = chunk_last ? LEN_W'(count_reg) : room;
    assign ctag       = chunk_last ? tag_reg : '0;

    assign idx_inc   = CW'(cur_last) + CW'(1);
    assign chunk_idx = (idx_inc >= CW'(size_c)) ? '0 : idx_inc[IW-1:0];
    assign act_inc   = cur_act + CFG_W'(1);
    assign exp_inc   = CW'(cur_exp) + CW'(1);
    assign exp_wrap  = (exp_inc >= CW'(size_c)) ? '0 : exp_inc[IW-1:0];

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        stat            = '0;
        stat.cmd        = cmd_reg;
        stat.zero_count = (count_reg == '0);
        stat.no_space   = (cur_act >= size_c) || (NC_W'(need) > NC_W'(size_c - cur_act));
        stat.chunk_more = !chunk_last && (act_inc < size_c);
        stat.ring_empty = (cur_act == '0);
        stat.ret_stop   = (CW'(seq_reg) == CW'(cur_exp)) || (cur_act == CFG_W'(1));
        stat.tag_nz     = (rd_data_reg != '0);
        stat.can_push   = !pend_valid_reg || out_free;
    end

    // Next result to hold
    always_comb begin
        new_res     = '0;
        new_res.dir = dir_reg;
        if (ctl.push_chunk) begin
            new_res.kind = KIND_DESC;
            new_res.idx  = IDX_W'(chunk_idx);
            new_res.addr = addr_reg;
            new_res.len  = CLEN_W'(len_c);
            new_res.tag  = ctag;
            new_res.irq  = (ctag != '0);
        end else if (ctl.retire) begin
            new_res.kind = (cmd_reg == CMD_HALT) ? KIND_ABORT : KIND_DONE;
            new_res.idx  = IDX_W'(cur_exp);
            new_res.tag  = rd_data_reg;
        end else begin
            new_res.kind = (count_reg == '0) ? KIND_EMPTY : KIND_NOSPACE;
            new_res.tag  = tag_reg;
        end
    end

    assign push_en = ctl.push_reject || ctl.push_chunk || (ctl.retire && stat.tag_nz);

    // Hold one result back so the final one of a request can carry last
    always_comb begin
        pend_valid_next = pend_valid_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        if (push_en) begin
            pend_valid_next = 1'b1;
            if (pend_valid_reg) begin
                m_tvalid_next = 1'b1;
            end
        end else if (ctl.flush && pend_valid_reg) begin
            pend_valid_next = 1'b0;
            m_tvalid_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            pend_reg <= new_res;
        end
        if ((push_en || ctl.flush) && pend_valid_reg) begin
            out_reg      <= pend_reg;
            out_last_reg <= !push_en;
        end
    end

    // Capture the request and walk the chunk cursor
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg   <= s_tuser;
            dir_reg   <= s_tdata[0];
            addr_reg  <= s_tdata[32:1];
            count_reg <= s_tdata[51:33];
            tag_reg   <= s_tdata[67:52];
            seq_reg   <= s_tdata[73:68];
        end else if (ctl.push_chunk) begin
            count_reg <= count_reg - CNT_W'(len_c);
            addr_reg  <= addr_reg + ADDR_W'(len_c);
        end
    end

    // Ring indices and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_entries_reg <= RING_ENTRIES_RST;
            for (int d = 0; d < 2; d++) begin
                last_index_reg[d]   <= LAST_RST;
                expect_index_reg[d] <= '0;
                active_count_reg[d] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                ring_entries_reg <= cfg_data;
            end
            if (ctl.push_chunk) begin
                last_index_reg[dir_reg]   <= chunk_idx;
                active_count_reg[dir_reg] <= act_inc;
            end
            if (ctl.retire) begin
                active_count_reg[dir_reg] <= cur_act - CFG_W'(1);
                expect_index_reg[dir_reg] <= exp_wrap;
            end
            if (ctl.flush && (cmd_reg == CMD_HALT)) begin
                expect_index_reg[dir_reg] <= '0;
                last_index_reg[dir_reg]   <= IW'(size_c - CFG_W'(1));
            end
        end
    end

    // Tag store: written on descriptor write, cleared on retire
    assign mem_we = ctl.push_chunk || ctl.retire;
    assign mem_wa = {dir_reg, ctl.push_chunk ? chunk_idx : cur_exp};
    assign mem_wd = ctl.push_chunk ? ctag : '0;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tag_mem[mem_wa] <= mem_wd;
        end
        if (ctl.rd_req) begin
            rd_data_reg <= tag_mem[{dir_reg, cur_exp}];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_reg.irq, out_reg.tag, out_reg.len,
                       out_reg.addr, out_reg.idx, out_reg.dir};

endmodule

// ===== design/sg_audio_dma_descriptor_ring_core.sv =====
// A submit checks the request, then writes one descriptor per chunk; completion and
// halt read the tag store, then retire, for each retired entry, and all of them can
// stall on a full result stage. One request is in work at a time.
// Results leave through an output register, so a new request is taken while
// the last result still waits. Reset (aresetn low, synchronous) sets the ring
// size to 64, empties both rings and drops any held result; the tag store is not cleared.
module sg_audio_dma_descriptor_ring_core #(
    parameter int RING_DEPTH = sgdr_pkg::SGDR_RING_DEPTH,
    parameter int PAGE_BYTES = sgdr_pkg::SGDR_PAGE_BYTES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata, from bit 0: direction, req_addr, req_count, req_tag, hw_seq, zero pad
    input  logic [sgdr_pkg::S_DATA_W-1:0]   s_tdata,
    // s_tuser: command
    input  logic [sgdr_pkg::CMD_W-1:0]      s_tuser,
    // Ring size register write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sgdr_pkg::CFG_W-1:0]      cfg_data,
    // Result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata, from bit 0: out_direction, entry_index, chunk_addr, chunk_len, tag,
    // irq_enable, zero pad
    output logic [sgdr_pkg::M_DATA_W-1:0]   m_tdata,
    // m_tuser: kind
    output logic [sgdr_pkg::KIND_W-1:0]     m_tuser,
    // m_tlast: final result of a request
    output logic                            m_tlast
);
    import sgdr_pkg::*;

    sgdr_ctl_t  ctl;
    sgdr_stat_t stat;

    // Register writes must happen only while idle; the block does not enforce it and always takes them
    assign cfg_ready = 1'b1;

    // Sequencer: dispatch by command, step chunks or retirements, then flush
    sgdr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // Ring state, tag store, page splitter and result staging
    sgdr_datapath #(
        .RING_DEPTH (RING_DEPTH),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== design/sgdr_checker.sv =====
// Port-level checks for the descriptor ring block, bound to the top level.
// Depends on sgdr_pkg for widths and result kind codes.
module sgdr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [sgdr_pkg::S_DATA_W-1:0]   s_tdata,
    input logic [sgdr_pkg::CMD_W-1:0]      s_tuser,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [sgdr_pkg::CFG_W-1:0]      cfg_data,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sgdr_pkg::M_DATA_W-1:0]   m_tdata,
    input logic [sgdr_pkg::KIND_W-1:0]     m_tuser,
    input logic                            m_tlast
);
    import sgdr_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= KIND_EMPTY))
        else $error("undefined result kind");

    a_irq_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_DESC) |-> (m_tdata[68] == (m_tdata[67:52] != '0)))
        else $error("interrupt flag disagrees with tag");

    a_reject_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == KIND_NOSPACE) || (m_tuser == KIND_EMPTY)) |-> m_tlast)
        else $error("rejected request must give a single result");

endmodule

bind sg_audio_dma_descriptor_ring_core sgdr_checker u_sgdr_checker (.*);
